### hdl/distance_vector_route_engine_core_assert.svh
`ifndef DISTANCE_VECTOR_ROUTE_ENGINE_CORE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DVRE_CHECK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dvre check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DVRE_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dvre check failed");

`endif

### hdl/dvre_pkg.sv
package dvre_pkg;

  localparam int ID_W        = 4;
  localparam int FIELD_W     = 16;
  localparam int MAX_RESULTS = 54;
  localparam int NRW         = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] REQ_UP     = 2'd0;
  localparam logic [1:0] REQ_ADVERT = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] KIND_ADVERT  = 2'd0;
  localparam logic [1:0] KIND_FORWARD = 2'd1;
  localparam logic [1:0] KIND_NOROUTE = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_ERR,
    EM_UP_NEW,
    EM_UP_OLD,
    EM_ROUTE,
    EM_FLOOD,
    EM_FWD_TGT,
    EM_LK_RESULT
  } emit_t;

  typedef enum logic {
    RD_ADV,
    RD_LK
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    up_commit;
    logic    adv_commit;
    logic    i_clr;
    logic    i_inc;
    logic    d_clr;
    logic    scan;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    lk_cmp;
    emit_t   emit;
    logic    finish;
  } dvre_cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       peer_hit;
    logic       tgt_hit;
    logic       tgt_ok;
    logic       full;
    logic       lonely;
    logic       adv_reject;
    logic       up_i_last;
    logic       nb_i_last;
    logic       scan_done;
    logic       out_free;
  } dvre_stat_t;

endpackage

### hdl/dvre_req_if.sv
interface dvre_req_if import dvre_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [ID_W-1:0]    peer_node;
  logic [ID_W-1:0]    target_node;
  logic [FIELD_W-1:0] cost_in;
  logic [FIELD_W-1:0] time_in;

  modport source (output valid, req_type, peer_node, target_node, cost_in, time_in,
                  input ready);
  modport sink (input valid, req_type, peer_node, target_node, cost_in, time_in,
                output ready);
endinterface

### hdl/dvre_res_if.sv
interface dvre_res_if import dvre_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         out_kind;
  logic [ID_W-1:0]    to_node;
  logic [ID_W-1:0]    about_node;
  logic [FIELD_W-1:0] cost_out;
  logic               last;

  modport source (output valid, out_kind, to_node, about_node, cost_out, last,
                  input ready);
  modport sink (input valid, out_kind, to_node, about_node, cost_out, last,
                output ready);
endinterface

### hdl/dvre_ctrl.sv
`include "distance_vector_route_engine_core_assert.svh"

module dvre_ctrl import dvre_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dvre_stat_t st,
  output dvre_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_UP_A,
    S_UP_B,
    S_UP_SCAN,
    S_ADV_CHK,
    S_ADV_FL,
    S_LK_RD,
    S_LK_CMP,
    S_LK_END,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (st.out_free) begin
          unique case (st.req_type)
            REQ_UP: begin
              if (st.peer_hit || st.full) begin
                cmd.emit  = EM_ERR;
                state_nxt = S_FIN;
              end else begin
                cmd.up_commit = 1'b1;
                cmd.i_clr     = 1'b1;
                state_nxt     = st.lonely ? S_FIN : S_UP_A;
              end
            end
            REQ_ADVERT: begin
              if (!st.peer_hit) begin
                cmd.emit  = EM_ERR;
                state_nxt = S_FIN;
              end else if (!st.tgt_ok) begin
                state_nxt = S_FIN;
              end else begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_ADV;
                state_nxt  = S_ADV_CHK;
              end
            end
            REQ_LOOKUP: begin
              if (st.tgt_hit) begin
                cmd.emit  = EM_FWD_TGT;
                state_nxt = S_FIN;
              end else if (!st.tgt_ok || st.lonely) begin
                cmd.emit  = EM_LK_RESULT;
                state_nxt = S_FIN;
              end else begin
                cmd.i_clr = 1'b1;
                state_nxt = S_LK_RD;
              end
            end
            default: begin
              cmd.emit  = EM_ERR;
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_UP_A: begin
        if (st.out_free) begin
          cmd.emit  = EM_UP_NEW;
          state_nxt = S_UP_B;
        end
      end
      S_UP_B: begin
        if (st.out_free) begin
          cmd.emit  = EM_UP_OLD;
          cmd.d_clr = 1'b1;
          state_nxt = S_UP_SCAN;
        end
      end
      S_UP_SCAN: begin
        if (st.out_free) begin
          cmd.scan = 1'b1;
          cmd.emit = EM_ROUTE;
          if (st.scan_done) begin
            cmd.i_inc = 1'b1;
            state_nxt = st.up_i_last ? S_FIN : S_UP_A;
          end
        end
      end
      S_ADV_CHK: begin
        if (st.out_free) begin
          if (st.adv_reject) begin
            state_nxt = S_FIN;
          end else begin
            cmd.adv_commit = 1'b1;
            cmd.i_clr      = 1'b1;
            state_nxt      = S_ADV_FL;
          end
        end
      end
      S_ADV_FL: begin
        if (st.out_free) begin
          cmd.emit  = EM_FLOOD;
          cmd.i_inc = 1'b1;
          if (st.nb_i_last) state_nxt = S_FIN;
        end
      end
      S_LK_RD: begin
        if (st.out_free) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_LK;
          state_nxt  = S_LK_CMP;
        end
      end
      S_LK_CMP: begin
        if (st.out_free) begin
          cmd.lk_cmp = 1'b1;
          cmd.i_inc  = 1'b1;
          state_nxt  = st.nb_i_last ? S_LK_END : S_LK_RD;
        end
      end
      S_LK_END: begin
        if (st.out_free) begin
          cmd.emit  = EM_LK_RESULT;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `DVRE_CHECK_NOW(a_idle_no_emit, state_r == S_IDLE, cmd.emit == EM_NONE && !cmd.finish)
  `DVRE_CHECK_NOW(a_stall_holds, state_r != S_IDLE && !st.out_free, cmd == '0)
  `DVRE_CHECK_NEXT(a_finish_idle, cmd.finish, state_r == S_IDLE)

endmodule

### hdl/dvre_datapath.sv
`include "distance_vector_route_engine_core_assert.svh"

module dvre_datapath import dvre_pkg::*; #(
  parameter int NODE_COUNT    = 16,
  parameter int MAX_NEIGHBORS = 4,
  parameter int COST_BITS     = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dvre_cmd_t          cmd,
  output dvre_stat_t         st,
  input  logic [1:0]         in_req_type,
  input  logic [ID_W-1:0]    in_peer_node,
  input  logic [ID_W-1:0]    in_target_node,
  input  logic [FIELD_W-1:0] in_cost_in,
  input  logic [FIELD_W-1:0] in_time_in,
  input  logic               cfg_we,
  input  logic [ID_W-1:0]    cfg_wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [ID_W-1:0]    out_to_node,
  output logic [ID_W-1:0]    out_about_node,
  output logic [FIELD_W-1:0] out_cost_out,
  output logic               out_last
);

  localparam int ENTRIES = MAX_NEIGHBORS * NODE_COUNT;
  localparam int AW      = $clog2(ENTRIES);
  localparam int CNTW    = $clog2(MAX_NEIGHBORS + 1);
  localparam int IXW     = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int DCW     = $clog2(NODE_COUNT + 1);
  localparam int DW      = $clog2(NODE_COUNT);
  localparam int EW      = COST_BITS + FIELD_W;
  localparam logic [COST_BITS-1:0] CMAX = '1;

  function automatic logic [COST_BITS-1:0] sat_in(input logic [FIELD_W-1:0] x);
    logic [EW-1:0] e;
    e = EW'(x);
    sat_in = (e > EW'(CMAX)) ? CMAX : e[COST_BITS-1:0];
  endfunction

  function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
                                                   input logic [COST_BITS-1:0] b);
    logic [COST_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[COST_BITS] ? CMAX : s[COST_BITS-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input logic [COST_BITS-1:0] c);
    logic [EW-1:0] e;
    e = EW'(c);
    to_field = e[FIELD_W-1:0];
  endfunction

  function automatic logic [AW-1:0] idx(input int row, input int col);
    idx = AW'(row * NODE_COUNT + col);
  endfunction

  // latched request
  logic [1:0]           req_r;
  logic [ID_W-1:0]      peer_r, tgt_r, own_r;
  logic [COST_BITS-1:0] cost_sat_r, time_sat_r;

  // neighbor table and routes
  logic [CNTW-1:0]      count_r;
  logic [ID_W-1:0]      id_r   [MAX_NEIGHBORS];
  logic [COST_BITS-1:0] time_r [MAX_NEIGHBORS];
  logic [ENTRIES-1:0]   known_r;
  logic [COST_BITS-1:0] cost_mem [ENTRIES];
  logic [COST_BITS-1:0] rd_data_r;

  // walk state
  logic [CNTW-1:0]      i_r;
  logic [DCW-1:0]       d_r;
  logic                 s1_v_r;
  logic [DW-1:0]        s1_d_r;
  logic                 found_r;
  logic [COST_BITS:0]   best_r;
  logic [ID_W-1:0]      best_id_r;

  // result staging: pend holds one result until the next one shows whether it is final
  logic [NRW-1:0]       n_r;
  logic                 pend_v_r;
  logic [1:0]           pend_kind_r;
  logic [ID_W-1:0]      pend_to_r, pend_about_r;
  logic [COST_BITS-1:0] pend_cost_r;
  logic                 out_valid_r, out_last_r;
  logic [1:0]           out_kind_r;
  logic [ID_W-1:0]      out_to_r, out_about_r;
  logic [FIELD_W-1:0]   out_cost_r;

  logic [MAX_NEIGHBORS-1:0] peer_hits, tgt_hits;
  logic [IXW-1:0]           p_enc, ix;
  logic                     out_free;
  logic                     rd_go;
  logic [AW-1:0]            rd_addr;
  logic [COST_BITS:0]       lk_sum;
  logic                     lk_known;

  logic                 em_v, em_take;
  logic [1:0]           em_kind;
  logic [ID_W-1:0]      em_to, em_about;
  logic [COST_BITS-1:0] em_cost;

  assign ix       = i_r[IXW-1:0];
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    p_enc = '0;
    for (int j = 0; j < MAX_NEIGHBORS; j++) begin
      peer_hits[j] = (CNTW'(j) < count_r) && (id_r[j] == peer_r);
      tgt_hits[j]  = (CNTW'(j) < count_r) && (id_r[j] == tgt_r);
    end
    for (int j = MAX_NEIGHBORS - 1; j >= 0; j--) begin
      if (peer_hits[j]) p_enc = IXW'(j);
    end
  end

  assign lk_known = known_r[idx(int'(ix), int'(tgt_r))];
  assign lk_sum   = {1'b0, time_r[ix]} + {1'b0, rd_data_r};

  always_comb begin
    st            = '0;
    st.req_type   = req_r;
    st.peer_hit   = |peer_hits;
    st.tgt_hit    = |tgt_hits;
    st.tgt_ok     = int'(tgt_r) < NODE_COUNT;
    st.full       = (count_r == CNTW'(MAX_NEIGHBORS));
    st.lonely     = (count_r == '0);
    st.adv_reject = known_r[idx(int'(p_enc), int'(tgt_r))] && (cost_sat_r > rd_data_r);
    st.up_i_last  = (i_r + CNTW'(2)) == count_r;
    st.nb_i_last  = (i_r + CNTW'(1)) == count_r;
    st.scan_done  = (d_r == DCW'(NODE_COUNT)) && !s1_v_r;
    st.out_free   = out_free;
  end

  // route cost memory, one read and one write port
  always_comb begin
    rd_go = cmd.rd_en || (cmd.scan && (d_r < DCW'(NODE_COUNT)));
    if (cmd.scan) begin
      rd_addr = idx(int'(ix), int'(d_r));
    end else begin
      unique case (cmd.rd_sel)
        RD_ADV:  rd_addr = idx(int'(p_enc), int'(tgt_r));
        RD_LK:   rd_addr = idx(int'(ix), int'(tgt_r));
        default: rd_addr = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) rd_data_r <= cost_mem[rd_addr];
    if (cmd.adv_commit) cost_mem[idx(int'(p_enc), int'(tgt_r))] <= cost_sat_r;
  end

  // result of this step
  always_comb begin
    em_v     = 1'b0;
    em_kind  = KIND_ADVERT;
    em_to    = '0;
    em_about = '0;
    em_cost  = '0;
    unique case (cmd.emit)
      EM_ERR: begin
        em_v    = 1'b1;
        em_kind = KIND_ERROR;
      end
      EM_UP_NEW: begin
        em_v     = 1'b1;
        em_to    = id_r[ix];
        em_about = peer_r;
        em_cost  = time_sat_r;
      end
      EM_UP_OLD: begin
        em_v     = 1'b1;
        em_to    = peer_r;
        em_about = id_r[ix];
        em_cost  = time_r[ix];
      end
      EM_ROUTE: begin
        // skip the new neighbor itself and this node
        em_v     = s1_v_r && known_r[idx(int'(ix), int'(s1_d_r))]
                   && (int'(s1_d_r) != int'(peer_r)) && (int'(s1_d_r) != int'(own_r));
        em_to    = peer_r;
        em_about = ID_W'(s1_d_r);
        em_cost  = sat_add(time_r[ix], rd_data_r);
      end
      EM_FLOOD: begin
        em_v     = (id_r[ix] != peer_r) && (id_r[ix] != tgt_r);
        em_to    = id_r[ix];
        em_about = tgt_r;
        em_cost  = sat_add(cost_sat_r, time_sat_r);
      end
      EM_FWD_TGT: begin
        em_v     = 1'b1;
        em_kind  = KIND_FORWARD;
        em_to    = tgt_r;
        em_about = tgt_r;
      end
      EM_LK_RESULT: begin
        em_v     = 1'b1;
        em_kind  = found_r ? KIND_FORWARD : KIND_NOROUTE;
        em_to    = found_r ? best_id_r : '0;
        em_about = tgt_r;
      end
      default: em_v = 1'b0;
    endcase
  end

  assign em_take = em_v && (n_r < NRW'(MAX_RESULTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r       <= '0;
      count_r     <= '0;
      known_r     <= '0;
      i_r         <= '0;
      d_r         <= '0;
      s1_v_r      <= 1'b0;
      found_r     <= 1'b0;
      n_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) own_r <= cfg_wdata;

      if (cmd.load) begin
        req_r      <= in_req_type;
        peer_r     <= in_peer_node;
        tgt_r      <= in_target_node;
        cost_sat_r <= sat_in(in_cost_in);
        time_sat_r <= sat_in(in_time_in);
        found_r    <= 1'b0;
        n_r        <= '0;
      end

      if (cmd.up_commit) begin
        id_r[count_r[IXW-1:0]]   <= peer_r;
        time_r[count_r[IXW-1:0]] <= time_sat_r;
        count_r                  <= count_r + CNTW'(1);
        for (int j = 0; j < NODE_COUNT; j++) begin
          known_r[idx(int'(count_r), j)] <= 1'b0;
        end
      end
      if (cmd.adv_commit) known_r[idx(int'(p_enc), int'(tgt_r))] <= 1'b1;

      if (cmd.i_clr) begin
        i_r <= '0;
      end else if (cmd.i_inc) begin
        i_r <= i_r + CNTW'(1);
      end

      if (cmd.d_clr) begin
        d_r    <= '0;
        s1_v_r <= 1'b0;
      end else if (cmd.scan) begin
        if (d_r < DCW'(NODE_COUNT)) begin
          s1_v_r <= 1'b1;
          s1_d_r <= d_r[DW-1:0];
          d_r    <= d_r + DCW'(1);
        end else begin
          s1_v_r <= 1'b0;
        end
      end

      if (cmd.lk_cmp && lk_known && (!found_r || lk_sum < best_r)) begin
        found_r   <= 1'b1;
        best_r    <= lk_sum;
        best_id_r <= id_r[ix];
      end

      // push the held result out once its successor or the end is known
      if (cmd.finish && pend_v_r) begin
        out_kind_r  <= pend_kind_r;
        out_to_r    <= pend_to_r;
        out_about_r <= pend_about_r;
        out_cost_r  <= to_field(pend_cost_r);
        out_last_r  <= 1'b1;
      end else if (em_take && pend_v_r) begin
        out_kind_r  <= pend_kind_r;
        out_to_r    <= pend_to_r;
        out_about_r <= pend_about_r;
        out_cost_r  <= to_field(pend_cost_r);
        out_last_r  <= 1'b0;
      end
      if ((cmd.finish || em_take) && pend_v_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.finish) begin
        pend_v_r <= 1'b0;
      end else if (em_take) begin
        pend_v_r     <= 1'b1;
        pend_kind_r  <= em_kind;
        pend_to_r    <= em_to;
        pend_about_r <= em_about;
        pend_cost_r  <= em_cost;
        n_r          <= n_r + NRW'(1);
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_to_node    = out_to_r;
  assign out_about_node = out_about_r;
  assign out_cost_out   = out_cost_r;
  assign out_last       = out_last_r;

  `DVRE_CHECK_NEXT(a_up_count, cmd.up_commit, count_r == $past(count_r) + 1'b1)
  `DVRE_CHECK_NEXT(a_finish_flush, cmd.finish, !pend_v_r)
  `DVRE_CHECK_NEXT(a_finish_last, cmd.finish && pend_v_r, out_valid_r && out_last_r)

endmodule

### hdl/distance_vector_route_engine_core.sv
// Channel  | Dir | Handshake          | Payload
// in_ch    | in  | valid/ready        | req_type, peer_node, target_node, cost_in, time_in
// out_ch   | out | valid/ready        | out_kind, to_node, about_node, cost_out, last
// cfg_*    | in  | cfg_we, no ready   | cfg_wdata = own_node
//
// One item at a time; in_ch.ready is high only between items.
// Up with b earlier neighbors: b walks of NODE_COUNT routes, one route per cycle while out_ch
//   is not stalled, from the single read port of the route cost memory.
// Advert floods each other neighbor in turn; lookup reads and compares each neighbor's route.
// Reset (rst_n low, synchronous) empties the neighbor table and all route valid bits.
// A stalled out_ch holds the whole walk; the output register keeps the last result.
module distance_vector_route_engine_core import dvre_pkg::*; #(
  parameter int NODE_COUNT    = 16,
  parameter int MAX_NEIGHBORS = 4,
  parameter int COST_BITS     = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  dvre_req_if.sink        in_ch,
  dvre_res_if.source      out_ch,
  input  logic            cfg_we,
  input  logic [ID_W-1:0] cfg_wdata
);

  dvre_cmd_t  cmd;
  dvre_stat_t st;

  dvre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  dvre_datapath #(
    .NODE_COUNT    (NODE_COUNT),
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .COST_BITS     (COST_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_req_type    (in_ch.req_type),
    .in_peer_node   (in_ch.peer_node),
    .in_target_node (in_ch.target_node),
    .in_cost_in     (in_ch.cost_in),
    .in_time_in     (in_ch.time_in),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_kind       (out_ch.out_kind),
    .out_to_node    (out_ch.to_node),
    .out_about_node (out_ch.about_node),
    .out_cost_out   (out_ch.cost_out),
    .out_last       (out_ch.last)
  );

endmodule
